// ----- rtl/ccrp_pkg.sv -----
// ----------------------------------------------------------------------------
// ccrp_pkg
// Shared constants, register indexes, state encoding and the command/status
// bundles between the rebalance planner controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ccrp_pkg;

	// defaults for the top level parameters
	localparam int MAX_COLORS_DEF = 32;
	localparam int COUNT_BITS_DEF = 24;

	// fixed port widths
	localparam int CNT_IN_W   = 24;
	localparam int NC_CFG_W   = 6;
	localparam int NV_W       = 24;
	localparam int COLOR_W    = 5;
	localparam int MOVE_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// plan limits
	localparam int MAX_MOVES = 64;
	localparam int MOVES_W   = 7;

	// average divider: one quotient bit per cycle
	localparam int DIV_STEPS = NV_W;
	localparam int DIV_CNT_W = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLORS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_VERTICES = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SRC_RD,
		ST_SRC_CHK,
		ST_TGT_RD,
		ST_TGT_CHK,
		ST_MOVE,
		ST_FLUSH
	} ccrp_state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic src_rd;
		logic src_init;
		logic src_next;
		logic tgt_rd;
		logic tgt_eval;
		logic tgt_next;
		logic move;
		logic flush;
	} ccrp_cmd_t;

	typedef struct packed {
		logic load_last;
		logic div_done;
		logic src_big;
		logic src_last;
		logic tgt_skip;
		logic tgt_last;
		logic src_done;
		logic limit_next;
		logic out_free;
	} ccrp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/color_class_rebalance_planner.sv -----
// ----------------------------------------------------------------------------
// color_class_rebalance_planner
// Collects per-color vertex counts and plans up to 64 vertex moves that bring
// oversized color classes down toward the integer average class size.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  cfg      | cfg_wen              | cfg_idx, cfg_wdata
//  in       | in_valid / in_ready  | class_count
//  out      | out_valid / out_ready| move_valid, source_color, target_color,
//           |                      | move_count, start_offset, last
//
//  each count is written into the size memory; the last one starts a plan
//  plan: the bit-serial average divider, then a read and a check per source
//    class, a read and a check per target class examined and a move state per
//    move, plus a closing flush; the single memory read port sets this pace
//  in_ready is low for the whole plan; output stalls hold the plan in place
//  no clearing pass after reset, the size memory needs no initial contents
// ----------------------------------------------------------------------------
`default_nettype none

module color_class_rebalance_planner #(
	parameter int MAX_COLORS = ccrp_pkg::MAX_COLORS_DEF,
	parameter int COUNT_BITS = ccrp_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration writes
	input  wire logic                             cfg_wen,
	input  wire logic [ccrp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [ccrp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// count items
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [ccrp_pkg::CNT_IN_W-1:0]    class_count,
	// move items
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  move_valid,
	output logic [ccrp_pkg::COLOR_W-1:0]          source_color,
	output logic [ccrp_pkg::COLOR_W-1:0]          target_color,
	output logic [ccrp_pkg::MOVE_W-1:0]           move_count,
	output logic [ccrp_pkg::MOVE_W-1:0]           start_offset,
	output logic                                  last
);

	// commands from the sequencer, status back from the datapath
	ccrp_pkg::ccrp_cmd_t cmd;
	ccrp_pkg::ccrp_sts_t sts;

	// sequencer: loading, division, source and target walk
	ccrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: size memory, divider, move math, result register
	ccrp_dp #(
		.MAX_COLORS (MAX_COLORS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.class_count  (class_count),
		.out_ready    (out_ready),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.move_valid   (move_valid),
		.source_color (source_color),
		.target_color (target_color),
		.move_count   (move_count),
		.start_offset (start_offset),
		.last         (last)
	);

`ifndef NO_ASSERTIONS
	// a new result never lands on one still waiting to be taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !(cmd.move || cmd.flush))
		else $error("result register overwritten while stalled");

	// the empty plan marker always closes its plan
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !move_valid) |-> last)
		else $error("empty plan marker without last");

	// after the closing result the block takes counts again
	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> in_ready)
		else $error("block not idle after plan end");

	// no count is taken while a plan is running
	a_no_load_in_plan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.tgt_rd || cmd.move) |-> !in_ready)
		else $error("count accepted during planning");
`endif

endmodule

`default_nettype wire

// ----- rtl/ccrp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ccrp_ctrl
// Sequencer for the rebalance planner: count loading, average division and
// the source/target walk of the planning pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ccrp_pkg::ccrp_sts_t sts,
	output ccrp_pkg::ccrp_cmd_t      cmd
);

	ccrp_pkg::ccrp_state_t state_q;
	ccrp_pkg::ccrp_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccrp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ccrp_pkg::ST_IDLE: begin
				if (in_valid && sts.load_last) state_nxt = ccrp_pkg::ST_DIV;
			end
			ccrp_pkg::ST_DIV: begin
				if (sts.div_done) state_nxt = ccrp_pkg::ST_SRC_RD;
			end
			ccrp_pkg::ST_SRC_RD: state_nxt = ccrp_pkg::ST_SRC_CHK;
			ccrp_pkg::ST_SRC_CHK: begin
				if (sts.src_big) state_nxt = ccrp_pkg::ST_TGT_RD;
				else if (sts.src_last) state_nxt = ccrp_pkg::ST_FLUSH;
				else state_nxt = ccrp_pkg::ST_SRC_RD;
			end
			ccrp_pkg::ST_TGT_RD: state_nxt = ccrp_pkg::ST_TGT_CHK;
			ccrp_pkg::ST_TGT_CHK: begin
				if (!sts.tgt_skip) state_nxt = ccrp_pkg::ST_MOVE;
				else if (!sts.tgt_last) state_nxt = ccrp_pkg::ST_TGT_RD;
				else if (sts.src_last) state_nxt = ccrp_pkg::ST_FLUSH;
				else state_nxt = ccrp_pkg::ST_SRC_RD;
			end
			ccrp_pkg::ST_MOVE: begin
				if (sts.out_free) begin
					if (sts.limit_next) state_nxt = ccrp_pkg::ST_FLUSH;
					else if (!sts.src_done && !sts.tgt_last) state_nxt = ccrp_pkg::ST_TGT_RD;
					else if (sts.src_last) state_nxt = ccrp_pkg::ST_FLUSH;
					else state_nxt = ccrp_pkg::ST_SRC_RD;
				end
			end
			ccrp_pkg::ST_FLUSH: begin
				if (sts.out_free) state_nxt = ccrp_pkg::ST_IDLE;
			end
			default: state_nxt = ccrp_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ccrp_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load      = in_valid;
				cmd.div_start = in_valid && sts.load_last;
			end
			ccrp_pkg::ST_DIV: cmd.div_step = 1'b1;
			ccrp_pkg::ST_SRC_RD: cmd.src_rd = 1'b1;
			ccrp_pkg::ST_SRC_CHK: begin
				cmd.src_init = sts.src_big;
				cmd.src_next = !sts.src_big && !sts.src_last;
			end
			ccrp_pkg::ST_TGT_RD: cmd.tgt_rd = 1'b1;
			ccrp_pkg::ST_TGT_CHK: begin
				cmd.tgt_eval = !sts.tgt_skip;
				cmd.tgt_next = sts.tgt_skip && !sts.tgt_last;
				cmd.src_next = sts.tgt_skip && sts.tgt_last && !sts.src_last;
			end
			ccrp_pkg::ST_MOVE: begin
				if (sts.out_free) begin
					cmd.move = 1'b1;
					if (!sts.limit_next) begin
						if (!sts.src_done && !sts.tgt_last) cmd.tgt_next = 1'b1;
						else cmd.src_next = !sts.src_last;
					end
				end
			end
			ccrp_pkg::ST_FLUSH: cmd.flush = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/ccrp_dp.sv -----
// ----------------------------------------------------------------------------
// ccrp_dp
// Datapath: configuration registers, class size memory, bit-serial average
// divider, move arithmetic, one-move lookahead and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrp_dp #(
	parameter int MAX_COLORS = ccrp_pkg::MAX_COLORS_DEF,
	parameter int COUNT_BITS = ccrp_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic [ccrp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [ccrp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic [ccrp_pkg::CNT_IN_W-1:0]    class_count,
	input  wire logic                             out_ready,
	input  wire ccrp_pkg::ccrp_cmd_t              cmd,
	output ccrp_pkg::ccrp_sts_t                   sts,
	output logic                                  out_valid,
	output logic                                  move_valid,
	output logic [ccrp_pkg::COLOR_W-1:0]          source_color,
	output logic [ccrp_pkg::COLOR_W-1:0]          target_color,
	output logic [ccrp_pkg::MOVE_W-1:0]           move_count,
	output logic [ccrp_pkg::MOVE_W-1:0]           start_offset,
	output logic                                  last
);

	localparam int CIDX_W = $clog2(MAX_COLORS);
	localparam int NC_W   = $clog2(MAX_COLORS + 1);
	localparam int CW     = COUNT_BITS;
	localparam int NV_W   = ccrp_pkg::NV_W;

	// configuration and load state
	logic [ccrp_pkg::NC_CFG_W-1:0] num_colors_q;
	logic [NV_W-1:0]               num_vertices_q;
	logic [CIDX_W-1:0]             load_q;
	logic [CW-1:0]                 avg_q;

	// effective color count
	logic [31:0]       nc_ext;
	logic [31:0]       eff_n_w;
	logic [NC_W-1:0]   eff_n;
	logic [NC_W-1:0]   nm1;
	logic [CIDX_W-1:0] last_idx;
	logic [CIDX_W-1:0] load_idx;
	logic              load_last;

	assign nc_ext = {{(32 - ccrp_pkg::NC_CFG_W){1'b0}}, num_colors_q};

	always_comb begin
		if (num_colors_q == '0) eff_n_w = 32'd1;
		else if (nc_ext > 32'(MAX_COLORS)) eff_n_w = 32'(MAX_COLORS);
		else eff_n_w = nc_ext;
	end

	assign eff_n     = eff_n_w[NC_W-1:0];
	assign nm1       = eff_n - NC_W'(1);
	assign last_idx  = nm1[CIDX_W-1:0];
	assign load_idx  = (NC_W'(load_q) >= eff_n) ? '0 : load_q;
	assign load_last = (load_idx == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_colors_q   <= ccrp_pkg::NC_CFG_W'(1);
			num_vertices_q <= '0;
			load_q         <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_idx)
					ccrp_pkg::REG_NUM_COLORS: num_colors_q <= cfg_wdata[ccrp_pkg::NC_CFG_W-1:0];
					ccrp_pkg::REG_NUM_VERTICES: num_vertices_q <= cfg_wdata[NV_W-1:0];
					default: ;
				endcase
			end
			if (cfg_wen && cfg_idx == ccrp_pkg::REG_NUM_COLORS) load_q <= '0;
			else if (cmd.load) load_q <= load_last ? '0 : load_idx + CIDX_W'(1);
		end
	end

	// average divider, restoring, msb first
	logic [NC_W-1:0]                 rem_q;
	logic [NV_W-1:0]                 dvd_q;
	logic [ccrp_pkg::DIV_CNT_W-1:0]  div_cnt_q;
	logic [NC_W:0]                   trial;
	logic                            trial_ge;
	logic [NC_W:0]                   rem_nxt;
	logic [NV_W-1:0]                 quo_nxt;
	logic [CW+NV_W-1:0]              quo_ext;
	logic                            div_last;

	assign trial    = {rem_q, dvd_q[NV_W-1]};
	assign trial_ge = (trial >= {1'b0, eff_n});
	assign rem_nxt  = trial_ge ? trial - {1'b0, eff_n} : trial;
	assign quo_nxt  = {dvd_q[NV_W-2:0], trial_ge};
	assign quo_ext  = {{CW{1'b0}}, quo_nxt};
	assign div_last = (div_cnt_q == ccrp_pkg::DIV_CNT_W'(ccrp_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			avg_q     <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + ccrp_pkg::DIV_CNT_W'(1);
			if (div_last) avg_q <= quo_ext[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			dvd_q <= num_vertices_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_nxt[NC_W-1:0];
			dvd_q <= quo_nxt;
		end
	end

	// class size memory, updated in place by the plan
	localparam int CNT_EXT = ccrp_pkg::CNT_IN_W;
	logic [CW-1:0]        sizes_mem [MAX_COLORS];
	logic [CW-1:0]        rd_q;
	logic [CW+CNT_EXT-1:0] cnt_ext;
	logic                 wr_en;
	logic [CIDX_W-1:0]    wr_addr;
	logic [CW-1:0]        wr_data;
	logic                 rd_en;
	logic [CIDX_W-1:0]    rd_addr;

	logic [CIDX_W-1:0] ci_q;
	logic [CIDX_W-1:0] ti_q;
	logic [CW-1:0]     src_rem_q;
	logic [CW-1:0]     off_q;
	logic [CW-1:0]     mv_s1;
	logic              src_done_s1;
	logic [CW-1:0]     left;
	logic [CW-1:0]     room;

	assign cnt_ext = {{CW{1'b0}}, class_count};
	assign wr_en   = cmd.load || cmd.move;
	assign wr_addr = cmd.move ? ti_q : load_idx;
	assign wr_data = cmd.move ? rd_q + mv_s1 : cnt_ext[CW-1:0];
	assign rd_en   = cmd.src_rd || cmd.tgt_rd;
	assign rd_addr = cmd.tgt_rd ? ti_q : ci_q;

	always_ff @(posedge clk) begin
		if (wr_en) sizes_mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= sizes_mem[rd_addr];
	end

	// walk indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= '0;
			ti_q <= '0;
		end else begin
			if (cmd.div_start) ci_q <= '0;
			else if (cmd.src_next) ci_q <= ci_q + CIDX_W'(1);
			if (cmd.src_init) ti_q <= last_idx;
			else if (cmd.tgt_next) ti_q <= ti_q - CIDX_W'(1);
		end
	end

	// move arithmetic
	assign left = src_rem_q - avg_q;
	assign room = avg_q - rd_q;

	always_ff @(posedge clk) begin
		if (cmd.src_init) begin
			src_rem_q <= rd_q;
			off_q     <= '0;
		end else if (cmd.move) begin
			src_rem_q <= src_rem_q - mv_s1;
			off_q     <= off_q + mv_s1;
		end
		if (cmd.tgt_eval) begin
			mv_s1       <= (room < left) ? room : left;
			src_done_s1 <= !(room < left);
		end
	end

	// one move held back so the final one can carry last
	logic                     pend_valid_q;
	logic [CIDX_W-1:0]        pend_src_q;
	logic [CIDX_W-1:0]        pend_tgt_q;
	logic [CW-1:0]            pend_cnt_q;
	logic [CW-1:0]            pend_off_q;
	logic [ccrp_pkg::MOVES_W-1:0] k_q;
	logic                     push;
	logic [CIDX_W+ccrp_pkg::COLOR_W-1:0] src_ext;
	logic [CIDX_W+ccrp_pkg::COLOR_W-1:0] tgt_ext;
	logic [CW+ccrp_pkg::MOVE_W-1:0]      mcnt_ext;
	logic [CW+ccrp_pkg::MOVE_W-1:0]      moff_ext;

	logic                          out_valid_q;
	logic                          out_mv_q;
	logic [ccrp_pkg::COLOR_W-1:0]  out_src_q;
	logic [ccrp_pkg::COLOR_W-1:0]  out_tgt_q;
	logic [ccrp_pkg::MOVE_W-1:0]   out_cnt_q;
	logic [ccrp_pkg::MOVE_W-1:0]   out_off_q;
	logic                          out_last_q;

	assign push     = (cmd.move && pend_valid_q) || cmd.flush;
	assign src_ext  = {{ccrp_pkg::COLOR_W{1'b0}}, pend_src_q};
	assign tgt_ext  = {{ccrp_pkg::COLOR_W{1'b0}}, pend_tgt_q};
	assign mcnt_ext = {{ccrp_pkg::MOVE_W{1'b0}}, pend_cnt_q};
	assign moff_ext = {{ccrp_pkg::MOVE_W{1'b0}}, pend_off_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.div_start) begin
				pend_valid_q <= 1'b0;
				k_q          <= '0;
			end else if (cmd.move) begin
				pend_valid_q <= 1'b1;
				k_q          <= k_q + ccrp_pkg::MOVES_W'(1);
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.move) begin
			pend_src_q <= ci_q;
			pend_tgt_q <= ti_q;
			pend_cnt_q <= mv_s1;
			pend_off_q <= off_q;
		end
		if (push) begin
			// empty plan marker when nothing is pending at flush
			out_mv_q   <= pend_valid_q;
			out_src_q  <= pend_valid_q ? src_ext[ccrp_pkg::COLOR_W-1:0] : '0;
			out_tgt_q  <= pend_valid_q ? tgt_ext[ccrp_pkg::COLOR_W-1:0] : '0;
			out_cnt_q  <= pend_valid_q ? mcnt_ext[ccrp_pkg::MOVE_W-1:0] : '0;
			out_off_q  <= pend_valid_q ? moff_ext[ccrp_pkg::MOVE_W-1:0] : '0;
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid    = out_valid_q;
	assign move_valid   = out_mv_q;
	assign source_color = out_src_q;
	assign target_color = out_tgt_q;
	assign move_count   = out_cnt_q;
	assign start_offset = out_off_q;
	assign last         = out_last_q;

	// status
	always_comb begin
		sts            = '0;
		sts.load_last  = load_last;
		sts.div_done   = div_last;
		sts.src_big    = (rd_q > avg_q);
		sts.src_last   = (ci_q == last_idx);
		sts.tgt_skip   = (ti_q == ci_q) || (rd_q >= avg_q);
		sts.tgt_last   = (ti_q == '0);
		sts.src_done   = src_done_s1;
		sts.limit_next = (k_q == ccrp_pkg::MOVES_W'(ccrp_pkg::MAX_MOVES - 1));
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire
